@@ rtl/ordered_list_append_delete_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Ordered list unit assertion macros
// Shared concurrent assertion forms used by the list unit RTL.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_APPEND_DELETE_UNIT_MACROS_SVH
`define ORDERED_LIST_APPEND_DELETE_UNIT_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define OLAD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list unit assertion failed");

// Next-cycle implication under synchronous active-low reset.
`define OLAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list unit assertion failed");

`endif

@@ rtl/olad_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered list unit package
// Word types, command and status codes shared by the list unit modules.
// ----------------------------------------------------------------------------
package olad_pkg;

  localparam int LIST_DEPTH_DEF = 16;
  localparam int VALUE_W        = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  localparam logic [2:0] STS_APPENDED = 3'd0;
  localparam logic [2:0] STS_FULL     = 3'd1;
  localparam logic [2:0] STS_REMOVED  = 3'd2;
  localparam logic [2:0] STS_NOTFOUND = 3'd3;
  localparam logic [2:0] STS_ENTRY    = 3'd4;
  localparam logic [2:0] STS_EMPTY    = 3'd5;

  typedef struct packed {
    logic [1:0] cmd;
    value_t     value;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    value_t     entry_value;
    logic       last;
  } out_word_t;

endpackage

@@ rtl/olad_mem.sv @@
// ----------------------------------------------------------------------------
// Ordered list entry store
// Single write port, single registered read port storage for list entries.
// ----------------------------------------------------------------------------
module olad_mem import olad_pkg::*; #(
  parameter int DEPTH = LIST_DEPTH_DEF,
  parameter int IDX_W = $clog2(LIST_DEPTH_DEF)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  value_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output value_t           rd_data
);

  value_t mem [DEPTH];
  value_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/ordered_list_append_delete_unit.sv @@
// ----------------------------------------------------------------------------
// Ordered list append/delete unit
// Bounded ordered list of signed words with append, remove and dump commands.
// ----------------------------------------------------------------------------
// Usage: a command word enters on in_word when in_valid is high and in_stall
// is low. Append stores the value at the tail, remove deletes the first entry
// equal to the value and closes the gap, dump returns every entry from head
// to tail. Each result word leaves on out_word under out_valid/out_stall, and
// the final word of a command carries last.
// Append gives its result in the cycle after acceptance. Remove reads and
// compares each entry searched in turn, then reads and writes back each
// entry moved, and ends with a result step. Dump reads each entry and then
// presents it before it reads the next. This pace is set by the single read
// port of the entry store, which the compare and the move steps share.
// The unit takes one command at a time; in_stall stays high until the last
// result of the current command is in the output register and that register
// is free to take a new word.
// Reset empties the list; store contents are not cleared.
// A stalled receiver holds the output register, and the sequencer waits at any step that must load it.
// ----------------------------------------------------------------------------
`include "ordered_list_append_delete_unit_macros.svh"

module ordered_list_append_delete_unit import olad_pkg::*; #(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_RM_RD, S_RM_CMP, S_SH_RD, S_SH_WR, S_DP_RD, S_DP_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  value_t           val_r, val_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic             out_free;
  logic             in_acc;
  logic [CNT_W-1:0] idx_inc;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  value_t           wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  value_t           rd_data;

  olad_mem #(
    .DEPTH (LIST_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign idx_inc  = CNT_W'(idx_r + 1'b1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r[IDX_W-1:0];
    wr_data       = rd_data;
    rd_en         = 1'b0;
    rd_addr       = idx_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          val_nxt = in_word.value;
          idx_nxt = '0;
          case (in_word.cmd)
            CMD_APPEND: begin
              out_valid_nxt = 1'b1;
              if (cnt_r == DEPTH_C) begin
                out_word_nxt = '{status: STS_FULL, entry_value: '0, last: 1'b1};
              end else begin
                wr_en        = 1'b1;
                wr_addr      = cnt_r[IDX_W-1:0];
                wr_data      = in_word.value;
                cnt_nxt      = CNT_W'(cnt_r + 1'b1);
                out_word_nxt = '{status: STS_APPENDED, entry_value: '0, last: 1'b1};
              end
            end
            CMD_REMOVE: begin
              state_nxt = S_RM_RD;
            end
            CMD_DUMP: begin
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_word_nxt  = '{status: STS_EMPTY, entry_value: '0, last: 1'b1};
              end else begin
                state_nxt = S_DP_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RM_RD: begin
        if (idx_r == cnt_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{status: STS_NOTFOUND, entry_value: '0, last: 1'b1};
            state_nxt     = S_IDLE;
          end
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_RM_CMP;
        end
      end
      S_RM_CMP: begin
        if (rd_data == val_r) begin
          state_nxt = S_SH_RD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_RM_RD;
        end
      end
      S_SH_RD: begin
        if (idx_inc >= cnt_r) begin
          if (out_free) begin
            cnt_nxt       = CNT_W'(cnt_r - 1'b1);
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{status: STS_REMOVED, entry_value: '0, last: 1'b1};
            state_nxt     = S_IDLE;
          end
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_inc[IDX_W-1:0];
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = S_SH_RD;
      end
      S_DP_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_DP_OUT;
      end
      S_DP_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{status: STS_ENTRY, entry_value: rd_data,
                            last: (idx_inc == cnt_r)};
          if (idx_inc == cnt_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_DP_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      val_r       <= val_nxt;
      out_word_r  <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `OLAD_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= DEPTH_C)
  `OLAD_ASSERT_NEXT(a_append_grows, clk, rst_n,
    in_acc && (in_word.cmd == CMD_APPEND) && (cnt_r != DEPTH_C),
    cnt_r == CNT_W'($past(cnt_r) + 1'b1))
  `OLAD_ASSERT_NEXT(a_append_result, clk, rst_n,
    in_acc && (in_word.cmd == CMD_APPEND), out_valid_r)
  `OLAD_ASSERT_NOW(a_idle_last, clk, rst_n,
    (state_r == S_IDLE) && out_valid_r, out_word_r.last)

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered list unit testbench
// Sends append, remove, dump and undefined commands to the list unit while
// the sender idles and the receiver stalls at random. A scoreboard keeps a
// shadow copy of the list, works out the result words of every accepted
// command and checks each result word as it leaves the unit.
// ----------------------------------------------------------------------------
module tb;
  import olad_pkg::*;

  localparam int         DEPTH           = LIST_DEPTH_DEF;
  localparam logic [1:0] CMD_UNDEFINED   = 2'd3;
  localparam int         CYCLE_LIMIT     = 400000;
  localparam int         DRAIN_CYCLES    = 4 * DEPTH + 20;
  localparam int         PRESSURE_CYCLES = 300;

  class list_checker;
    value_t    shadow_entries[$];
    out_word_t expected_words[$];
    int        errors = 0;

    function void push_word(logic [2:0] status, value_t entry, logic last);
      out_word_t w;
      w.status      = status;
      w.entry_value = entry;
      w.last        = last;
      expected_words.push_back(w);
    endfunction

    function void note_command(in_word_t w);
      int hit;
      hit = -1;
      case (w.cmd)
        CMD_APPEND: begin
          if (shadow_entries.size() >= DEPTH) begin
            push_word(STS_FULL, '0, 1'b1);
          end else begin
            shadow_entries.push_back(w.value);
            push_word(STS_APPENDED, '0, 1'b1);
          end
        end
        CMD_REMOVE: begin
          foreach (shadow_entries[i]) begin
            if (hit < 0 && shadow_entries[i] == w.value) begin
              hit = i;
            end
          end
          if (hit < 0) begin
            push_word(STS_NOTFOUND, '0, 1'b1);
          end else begin
            shadow_entries.delete(hit);
            push_word(STS_REMOVED, '0, 1'b1);
          end
        end
        CMD_DUMP: begin
          if (shadow_entries.size() == 0) begin
            push_word(STS_EMPTY, '0, 1'b1);
          end else begin
            foreach (shadow_entries[i]) begin
              push_word(STS_ENTRY, shadow_entries[i], i == shadow_entries.size() - 1);
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word status=%0d value=%0d last=%0b",
                         got.status, got.entry_value, got.last));
      end else begin
        want = expected_words.pop_front();
        if (got.status !== want.status) begin
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        end
        if (got.entry_value !== want.entry_value) begin
          report($sformatf("entry_value %0d, expected %0d", got.entry_value,
                           want.entry_value));
        end
        if (got.last !== want.last) begin
          report($sformatf("last %0b, expected %0b", got.last, want.last));
        end
      end
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          pressure_req   = 1'b0;
  int          hold_left      = 0;
  int          cycle_count    = 0;
  value_t      value_pool[8];
  list_checker board = new();

  ordered_list_append_delete_unit #(
    .LIST_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (pressure_req) begin
      pressure_req = 1'b0;
      hold_left    = PRESSURE_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_word);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] cmd, input value_t value);
    in_word_t w;
    w.cmd   = cmd;
    w.value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!(in_valid && !in_stall));
    board.note_command(w);
  endtask

  function automatic value_t pick_value();
    if ($urandom_range(99) < 60) begin
      return value_pool[$urandom_range(7)];
    end
    return $urandom;
  endfunction

  task automatic run_random(input int count, input int send_pct, input int recv_pct,
                            input int append_pct);
    int     done;
    int     roll;
    value_t v;
    done           = 0;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (done < count) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        send_word(CMD_UNDEFINED, $urandom);
      end else if (roll < 3 + append_pct) begin
        send_word(CMD_APPEND, pick_value());
        done++;
      end else if (roll < 88) begin
        if (board.shadow_entries.size() > 0 && $urandom_range(99) < 65) begin
          v = board.shadow_entries[$urandom_range(board.shadow_entries.size() - 1)];
        end else begin
          v = pick_value();
        end
        send_word(CMD_REMOVE, v);
        done++;
      end else begin
        send_word(CMD_DUMP, $urandom);
        done++;
      end
    end
  endtask

  initial begin
    int k;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = '0;
    value_pool[3] = '1;
    for (k = 4; k < 8; k++) begin
      value_pool[k] = $urandom;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(CMD_DUMP, '0);
    send_word(CMD_REMOVE, 32'sd5);
    send_word(CMD_UNDEFINED, '1);
    send_word(CMD_APPEND, 32'sh8000_0000);
    send_word(CMD_APPEND, 32'sh7fff_ffff);
    send_word(CMD_APPEND, '0);
    send_word(CMD_APPEND, '1);
    send_word(CMD_APPEND, 32'sh8000_0000);
    send_word(CMD_REMOVE, 32'sh8000_0000);
    send_word(CMD_DUMP, '0);
    send_word(CMD_REMOVE, '1);
    for (k = 0; k < DEPTH - 3; k++) begin
      send_word(CMD_APPEND, $urandom);
    end
    send_word(CMD_APPEND, 32'sh1234_5678);
    send_word(CMD_DUMP, '1);

    run_random(24, 0, 0, 60);
    run_random(24, 83, 0, 40);
    run_random(24, 0, 83, 60);
    run_random(24, 7, 7, 40);

    // The receiver holds off while commands keep coming, so the unit backs up.
    pressure_req = 1'b1;
    run_random(10, 0, 0, 50);

    in_valid <= 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ ordered_list_append_delete_unit.f @@
+incdir+rtl
rtl/olad_pkg.sv
rtl/olad_mem.sv
rtl/ordered_list_append_delete_unit.sv
tb/tb.sv
